>>> rtl/sktab_pkg.sv
// Shared types, constants and helpers for the sorted key table search unit.
`default_nettype none

package sktab_pkg;

  // Table geometry defaults
  localparam int unsigned MaxEntries  = 256;
  localparam int unsigned MaxKeyBytes = 8;

  // Field widths
  localparam int unsigned KeyW     = 64;
  localparam int unsigned IdxFldW  = 8;
  localparam int unsigned CntRegW  = 9;
  localparam int unsigned LenRegW  = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgEntryCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyLength  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgThreshold  = 2'd2;

  // Configuration reset values
  localparam logic [CntRegW-1:0] EntryCountRst = 9'd1;
  localparam logic [LenRegW-1:0] KeyLengthRst  = 4'd1;
  localparam logic [CntRegW-1:0] ThresholdRst  = 9'd8;

  // Request kinds carried on tuser
  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  // Outcome of one key compare
  typedef struct packed {
    logic eq;  // masked entry equals masked query
    logic lt;  // masked query below masked entry
  } cmp_res_t;

  // Byte mask covering the low nbytes bytes of a key
  function automatic logic [KeyW-1:0] key_mask(input logic [LenRegW-1:0] nbytes);
    logic [KeyW-1:0] m;
    m = '0;
    for (int i = 0; i < KeyW / 8; i++) begin
      m[i*8 +: 8] = (LenRegW'(i) < nbytes) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/sktab_cmp.sv
// Shared key comparator: masked equality and unsigned ordering of two keys.
`default_nettype none

module sktab_cmp (
  input  wire logic [sktab_pkg::KeyW-1:0] query_i,   // already masked
  input  wire logic [sktab_pkg::KeyW-1:0] entry_i,
  input  wire logic [sktab_pkg::KeyW-1:0] mask_i,
  output sktab_pkg::cmp_res_t             res_o
);

  logic [sktab_pkg::KeyW-1:0] entry_m;

  // Big-endian packing makes a plain unsigned compare lexicographic
  assign entry_m   = entry_i & mask_i;
  assign res_o.eq  = (entry_m == query_i);
  assign res_o.lt  = (query_i < entry_m);

endmodule

`default_nettype wire

>>> rtl/sorted_key_table_search_unit.sv
// Top level: key table memory, search sequencer and stream ports.
//
// Usage: requests enter on the s_axis channel. tuser carries the kind (0 load,
// 1 query). A load writes one table slot; a query looks its key up in the
// first entry_count slots. Every request yields exactly one result on the
// m_axis channel. The cfg channel is always ready; the user must write the
// configuration only while no request is in flight; the unit does no check.
//
// Sequencing: a load goes straight to result delivery; a query alternates a
// read state and a compare state per probe until a hit or an empty range.
// s_axis_tready returns as the result is registered, once the output register
// is free. Each probe is a registered read of the table memory and a pass
// through the shared comparator. A linear scan (entry count at or below
// small_threshold) makes up to entry_count probes; a binary search up to
// ceil(log2(entry_count + 1)). One request at a time.
//
// Reset clears the sequencer, the output valid and the configuration
// registers (entry_count 1, key_length 1, small_threshold 8); table contents
// are undefined until loaded. A stalled receiver holds the result in the
// output register; the unit still takes one further request and parks its
// result until the register frees.
`default_nettype none

module sorted_key_table_search_unit #(
  parameter int unsigned MAX_ENTRIES   = sktab_pkg::MaxEntries,
  parameter int unsigned MAX_KEY_BYTES = sktab_pkg::MaxKeyBytes
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Request stream
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  // [7:0] entry_index, [71:8] key, [72] pattern_end, [79:73] zero
  input  wire logic [sktab_pkg::InDataW-1:0]      s_axis_tdata,
  // [0] op
  input  wire logic                               s_axis_tuser,
  // Result stream
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [0] found, [8:1] match_index, [9] is_end, [13:10] advance, [15:14] zero
  output      logic [sktab_pkg::OutDataW-1:0]     m_axis_tdata,
  // Configuration writes
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [sktab_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [sktab_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > sktab_pkg::CntRegW) ? CntW : sktab_pkg::CntRegW;
  localparam int unsigned KeyW = sktab_pkg::KeyW;
  localparam int unsigned LenW = sktab_pkg::LenRegW;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  // Configuration registers
  logic [sktab_pkg::CntRegW-1:0] cnt_q, thr_q;
  logic [LenW-1:0]               len_q;

  // Sequencer state
  state_e          state_q, state_d;
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, ptr_q, ptr_d;
  logic            lin_q, lin_d;
  logic [KeyW-1:0] qry_q, qry_d;
  logic            fnd_q, fnd_d, end_q, end_d;

  // Output register
  logic                          m_valid_q;
  logic [sktab_pkg::OutDataW-1:0] m_data_q, m_data_d;

  // Table memory: {pattern_end, key}
  logic [KeyW:0]   mem_q [MAX_ENTRIES];
  logic [KeyW:0]   rd_q;
  logic            wr_en, rd_en;
  logic [IdxW-1:0] wr_addr, rd_addr;

  // Request fields
  logic                         in_op, in_pe;
  logic [sktab_pkg::IdxFldW-1:0] in_idx;
  logic [KeyW-1:0]              in_key;

  logic                   s_acc, out_load;
  logic [LenW-1:0]        len_eff;
  logic [KeyW-1:0]        mask;
  logic [CmpW-1:0]        cnt_ext, cnt_sat;
  logic [CntW-1:0]        cnt_eff;
  logic [CntW:0]          mid_sum;
  logic [CntW-1:0]        probe;
  sktab_pkg::cmp_res_t    cmp;

  assign in_idx = s_axis_tdata[7:0];
  assign in_key = s_axis_tdata[71:8];
  assign in_pe  = s_axis_tdata[72];
  assign in_op  = s_axis_tuser;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= sktab_pkg::EntryCountRst;
      len_q <= sktab_pkg::KeyLengthRst;
      thr_q <= sktab_pkg::ThresholdRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sktab_pkg::CfgEntryCount: cnt_q <= cfg_data_i;
        sktab_pkg::CfgKeyLength:  len_q <= cfg_data_i[LenW-1:0];
        sktab_pkg::CfgThreshold:  thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective key length and entry count
  always_comb begin
    if (len_q == '0) begin
      len_eff = LenW'(1);
    end else if (len_q > LenW'(MAX_KEY_BYTES)) begin
      len_eff = LenW'(MAX_KEY_BYTES);
    end else begin
      len_eff = len_q;
    end
    cnt_ext = CmpW'(cnt_q);
    cnt_sat = (cnt_ext > CmpW'(MAX_ENTRIES)) ? CmpW'(MAX_ENTRIES) : cnt_ext;
    cnt_eff = cnt_sat[CntW-1:0];
  end

  assign mask = sktab_pkg::key_mask(len_eff);

  // Probe address: scan pointer or midpoint of the open range
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (CntW+1)'(1);
  assign probe   = lin_q ? lo_q : mid_sum[CntW:1];

  // Shared comparator
  sktab_cmp u_cmp (
    .query_i (qry_q),
    .entry_i (rd_q[KeyW-1:0]),
    .mask_i  (mask),
    .res_o   (cmp)
  );

  // Memory ports
  assign wr_en   = s_acc && (in_op == sktab_pkg::OpLoad)
                   && ({24'd0, in_idx} < 32'(MAX_ENTRIES));
  assign wr_addr = IdxW'(in_idx);
  assign rd_en   = (state_q == ST_READ);
  assign rd_addr = IdxW'(probe);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= {in_pe, in_key};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Search sequencer
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    ptr_d   = ptr_q;
    lin_d   = lin_q;
    qry_d   = qry_q;
    fnd_d   = fnd_q;
    end_d   = end_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          fnd_d = 1'b0;
          end_d = 1'b0;
          lo_d  = '0;
          hi_d  = cnt_eff;
          lin_d = (CmpW'(cnt_eff) <= CmpW'(thr_q));
          qry_d = in_key & mask;
          state_d = (in_op == sktab_pkg::OpQuery) ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        if (lo_q < hi_q) begin
          ptr_d   = probe;
          state_d = ST_CMP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CMP: begin
        if (cmp.eq) begin
          fnd_d   = 1'b1;
          end_d   = rd_q[KeyW];
          state_d = ST_DONE;
        end else begin
          if (lin_q || !cmp.lt) begin
            lo_d = ptr_q + CntW'(1);
          end else begin
            hi_d = ptr_q;
          end
          state_d = ST_READ;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    ptr_q <= ptr_d;
    lin_q <= lin_d;
    qry_q <= qry_d;
    fnd_q <= fnd_d;
    end_q <= end_d;
  end

  // Result packing and output register
  assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    m_data_d = '0;
    if (fnd_q) begin
      m_data_d = {2'b00, len_eff, end_q, sktab_pkg::IdxFldW'(ptr_q), 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
  // Sequencer state stays one-hot
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  // Search range never inverts while probing
  a_range_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ || state_q == ST_CMP) |-> (lo_q <= hi_q))
    else $error("search range inverted");

  // A probed slot lies inside the open range
  a_probe_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (ptr_q >= lo_q && ptr_q < hi_q))
    else $error("probe outside search range");

  // A load goes straight to result delivery
  a_load_direct : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && in_op == sktab_pkg::OpLoad) |=> (state_q == ST_DONE))
    else $error("load did not finish at once");

  // A hit always reports a non-zero advance
  a_hit_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[13:10] != 4'd0))
    else $error("hit with zero advance");
`endif

endmodule

`default_nettype wire

>>> dv/tb_sorted_key_table_search_unit.sv
// Self-checking testbench for the sorted key table search unit: streamed loads and queries.

module tb_sorted_key_table_search_unit;
  import sktab_pkg::*;

  localparam int unsigned TableDepth  = 256;
  localparam int unsigned TargetItems = 1350;
  localparam int unsigned QuietTail   = 1150;  // no idling once this many requests are queued
  localparam int unsigned StallLimit  = 5000;  // cycles without any handshake
  localparam int unsigned DrainCycles = 600;   // longer than a full 256-entry scan

  // One request as carried on s_axis
  typedef struct packed {
    logic            op;
    logic [7:0]      slot;
    logic [KeyW-1:0] key;
    logic            pat_end;
  } request_t;

  // One lookup result as carried on m_axis
  typedef struct packed {
    logic       found;
    logic [7:0] slot;
    logic       is_end;
    logic [3:0] advance;
  } lookup_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // Predictor copy of the table and the registers
  logic [KeyW-1:0]    stored_key [TableDepth];
  logic               stored_end [TableDepth];
  logic [CntRegW-1:0] used_count = EntryCountRst;
  logic [LenRegW-1:0] key_bytes  = KeyLengthRst;
  logic [CntRegW-1:0] scan_limit = ThresholdRst;

  lookup_t  expected_lookups [$];
  request_t request_queue [$];

  // Stimulus-side view of what has been loaded
  logic [KeyW-1:0] gen_key [TableDepth];
  bit              gen_written [TableDepth];

  int  outstanding = 0;
  int  n_errors = 0, n_sent = 0, n_loads = 0, n_queries = 0, n_hits = 0;
  int  n_linear = 0, n_binary = 0, n_phases = 0, idle_cycles = 0;
  bit  in_fire = 1'b0;
  bit  idle_send = 1'b0, idle_recv = 1'b0;
  int  send_gap = 0, recv_gap = 0;

  always #5 clk_i = ~clk_i;

  sorted_key_table_search_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Key length as used: 0 reads as 1, anything above the maximum saturates
  function automatic int unsigned clamp_bytes(input int unsigned len);
    if (len < 1) return 1;
    if (len > MaxKeyBytes) return MaxKeyBytes;
    return len;
  endfunction

  function automatic logic [KeyW-1:0] bytes_mask(input int unsigned nbytes);
    if (nbytes >= 8) return '1;
    return (KeyW'(1) << (8 * nbytes)) - KeyW'(1);
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Expected result of one request; a load also updates the table copy
  function automatic lookup_t lookup_result(input request_t req);
    lookup_t         res;
    int unsigned     nbytes, cnt, hit, i;
    logic [KeyW-1:0] m, q, e;
    int              lo, hi, mid;
    bit              hit_ok;
    res    = '0;
    hit    = 0;
    hit_ok = 1'b0;
    if (req.op == OpLoad) begin
      stored_key[req.slot] = req.key;
      stored_end[req.slot] = req.pat_end;
      n_loads++;
      return res;
    end
    n_queries++;
    nbytes = clamp_bytes(key_bytes);
    m      = bytes_mask(nbytes);
    q      = req.key & m;
    cnt    = (used_count > TableDepth) ? TableDepth : used_count;
    if (cnt != 0 && cnt <= scan_limit) begin
      // linear scan, first equal slot wins
      n_linear++;
      for (i = 0; i < cnt && !hit_ok; i++) begin
        if ((stored_key[i] & m) == q) begin
          hit_ok = 1'b1;
          hit    = i;
        end
      end
    end else if (cnt != 0) begin
      // binary search, assumes ascending keys
      n_binary++;
      lo = 0;
      hi = int'(cnt) - 1;
      while (lo <= hi && !hit_ok) begin
        mid = (lo + hi) / 2;
        e   = stored_key[mid] & m;
        if (e == q) begin
          hit_ok = 1'b1;
          hit    = mid;
        end else if (q < e) begin
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
    end
    if (hit_ok) begin
      n_hits++;
      res.found   = 1'b1;
      res.slot    = 8'(hit);
      res.is_end  = stored_end[hit];
      res.advance = 4'(nbytes);
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Capture of config writes, requests and results; watchdog last
  always @(posedge clk_i) begin
    request_t req;
    lookup_t  want, got;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgEntryCount: used_count = cfg_data_i;
          CfgKeyLength:  key_bytes  = cfg_data_i[LenRegW-1:0];
          CfgThreshold:  scan_limit = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.op      = s_axis_tuser;
        req.slot    = s_axis_tdata[7:0];
        req.key     = s_axis_tdata[71:8];
        req.pat_end = s_axis_tdata[72];
        expected_lookups.push_back(lookup_result(req));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tdata[9], m_axis_tdata[13:10]};
        outstanding--;
        if (expected_lookups.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none, got %0h", $time, m_axis_tdata);
        end else begin
          want = expected_lookups.pop_front();
          compare_field("found", want.found, got.found);
          compare_field("match_index", want.slot, got.slot);
          compare_field("is_end", want.is_end, got.is_end);
          compare_field("advance", want.advance, got.advance);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Request driver, fed from the queue; idles in bursts when enabled
  always @(negedge clk_i) begin
    request_t nxt;
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (request_queue.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (idle_send && (n_sent < QuietTail) && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 11);
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = request_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.op;
        s_axis_tdata  <= {7'b0, nxt.pat_end, nxt.key, nxt.slot};
      end
    end
  end

  // Result receiver, stalls in bursts when enabled
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_recv && (n_sent < QuietTail) && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send(input logic op, input logic [7:0] slot, input logic [KeyW-1:0] key,
                      input logic pe);
    request_t r;
    r.op      = op;
    r.slot    = slot;
    r.key     = key;
    r.pat_end = pe;
    request_queue.push_back(r);
    outstanding++;
    n_sent++;
    if (op == OpLoad) begin
      gen_key[slot]     = key;
      gen_written[slot] = 1'b1;
    end
  endtask

  task automatic wait_idle();
    while (outstanding > 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgDataW'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One setting: reprogram when idle, maybe reload the table, then mostly queries
  task automatic run_phase(input int unsigned count, input int unsigned len,
                           input int unsigned thr, input int unsigned n_req,
                           input bit force_build);
    int unsigned     n, nb, slot, i, r;
    logic [KeyW-1:0] m, step, k;
    logic [KeyW-1:0] pool [4];
    bit              have_tbl, sorted;
    wait_idle();
    write_reg(CfgEntryCount, count);
    write_reg(CfgKeyLength, len);
    write_reg(CfgThreshold, thr);
    n_phases++;
    idle_send = (n_sent < QuietTail) && ($urandom_range(0, 3) != 0);
    idle_recv = (n_sent < QuietTail) && ($urandom_range(0, 3) != 0);
    n  = (count > TableDepth) ? TableDepth : count;
    nb = clamp_bytes(len);
    m  = bytes_mask(nb);
    have_tbl = 1'b1;
    for (i = 0; i < n; i++)
      if (!gen_written[i]) have_tbl = 1'b0;
    // table build: ascending for binary search, duplicate-heavy otherwise
    if (n > 0 && (force_build || !have_tbl ||
                  $urandom_range(0, 99) < ((n > 64) ? 15 : 45))) begin
      sorted = (n > thr) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 3) == 0);
      step   = (nb >= 8) ? ({KeyW{1'b1}} / KeyW'(n)) : ((KeyW'(1) << (8 * nb)) / KeyW'(n));
      for (i = 0; i < 4; i++) pool[i] = rand_key();
      for (i = 0; i < n; i++) begin
        if (sorted)
          k = KeyW'(i) * step + (rand_key() % step);
        else if ($urandom_range(0, 1) == 1)
          k = pool[$urandom_range(0, 3)] & m;
        else
          k = rand_key() & m;
        send(OpLoad, 8'(i), (rand_key() & ~m) | k, 1'($urandom_range(0, 1)));
      end
    end
    for (i = 0; i < n_req; i++) begin
      r    = $urandom_range(0, 99);
      slot = (n > 0) ? $urandom_range(0, n - 1) : 0;
      if ($urandom_range(0, 49) == 0) wait_idle();
      if (r < 8) begin
        send(OpLoad, 8'($urandom), rand_key(), 1'($urandom_range(0, 1)));
      end else if (r < 68 && n > 0) begin
        // hit: same masked bytes, junk above them
        send(OpQuery, 8'($urandom), (rand_key() & ~m) | (gen_key[slot] & m),
             1'($urandom_range(0, 1)));
      end else if (r < 80 && n > 0) begin
        // near miss just above or below a stored key
        k = ($urandom_range(0, 1) == 1) ? (gen_key[slot] + 1) : (gen_key[slot] - 1);
        send(OpQuery, 8'($urandom), k, 1'($urandom_range(0, 1)));
      end else if (r < 86) begin
        send(OpQuery, 8'($urandom), ($urandom_range(0, 1) == 1) ? '1 : '0,
             1'($urandom_range(0, 1)));
      end else begin
        send(OpQuery, 8'($urandom), rand_key(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Stimulus: directed part, fixed corner settings, then random settings
  initial begin
    int unsigned cnt, len, thr, sel;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset setting: one entry, one-byte keys, linear scan
    send(OpLoad, 8'd0, '1, 1'b1);
    send(OpQuery, 8'd0, 64'h0000_0000_0000_00FF, 1'b0);
    send(OpQuery, 8'hFF, '1, 1'b1);
    send(OpQuery, 8'd0, '0, 1'b0);
    send(OpLoad, 8'd255, '0, 1'b0);
    send(OpLoad, 8'd0, '0, 1'b0);
    send(OpQuery, 8'd0, '0, 1'b0);
    send(OpLoad, 8'd1, 64'h10, 1'b0);
    send(OpLoad, 8'd2, 64'h20, 1'b1);
    send(OpLoad, 8'd3, 64'h77, 1'b1);
    send(OpLoad, 8'd4, 64'h30, 1'b0);
    send(OpLoad, 8'd5, 64'h77, 1'b0);
    send(OpLoad, 8'd6, 64'h90, 1'b1);
    send(OpLoad, 8'd7, 64'hF0, 1'b1);
    // eight entries, linear: duplicate key returns the first slot
    wait_idle();
    write_reg(CfgEntryCount, 8);
    send(OpQuery, 8'd0, 64'h77, 1'b0);
    send(OpQuery, 8'd0, 64'hF0, 1'b0);
    send(OpQuery, 8'd0, 64'h55, 1'b0);
    // same unsorted table through the binary search
    wait_idle();
    write_reg(CfgThreshold, 7);
    send(OpQuery, 8'd0, 64'h77, 1'b0);
    send(OpQuery, 8'd0, 64'h10, 1'b0);
    send(OpQuery, 8'd0, 64'hF0, 1'b0);

    // corner settings: full table, oversized registers, empty table, tiny tables
    run_phase(256, 8, 0, 30, 1'b1);
    run_phase(511, 15, 511, 20, 1'b0);
    run_phase(0, 0, 8, 10, 1'b0);
    run_phase(1, 1, 0, 15, 1'b1);
    run_phase(2, 3, 256, 15, 1'b1);

    while (n_sent < TargetItems) begin
      sel = $urandom_range(0, 99);
      if (sel < 4)       cnt = 0;
      else if (sel < 60) cnt = $urandom_range(1, 16);
      else if (sel < 82) cnt = $urandom_range(17, 64);
      else if (sel < 93) cnt = $urandom_range(65, 256);
      else               cnt = $urandom_range(257, 511);
      if ($urandom_range(0, 9) == 0)
        len = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(9, 15);
      else
        len = $urandom_range(1, 8);
      sel = $urandom_range(0, 5);
      case (sel)
        0:       thr = 0;
        1:       thr = cnt;
        2:       thr = (cnt > 0) ? cnt - 1 : 0;
        3:       thr = 511;
        4:       thr = $urandom_range(0, 511);
        default: thr = $urandom_range(0, 64);
      endcase
      run_phase(cnt, len, thr, $urandom_range(20, 50), 1'b0);
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_lookups.size() != 0) begin
      n_errors++;
      $display("%0t: results still owed, expected %0d more, got none",
               $time, expected_lookups.size());
    end
    $display("Run: %0d requests (%0d loads, %0d queries, %0d hits) across %0d settings.",
             n_sent, n_loads, n_queries, n_hits, n_phases + 1);
    $display("Lookups: %0d linear scans, %0d binary searches, %0d errors.",
             n_linear, n_binary, n_errors);
    if (n_errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
